// ----- rtl/core/utf8_text_detector_core_macros.svh -----
// ----------------------------------------------------------------------------
// UTF-8 text detector assertion macros
// Shared concurrent assertion wrappers, clocked on clk_i and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef UTF8_TEXT_DETECTOR_CORE_MACROS_SVH
`define UTF8_TEXT_DETECTOR_CORE_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication
`define UTD_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("utf8 text detector check failed");

// Next-cycle implication
`define UTD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("utf8 text detector check failed");

`else

`define UTD_ASSERT_IMPL(lbl, ante, cons)
`define UTD_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// ----- rtl/core/utd_pkg.sv -----
// ----------------------------------------------------------------------------
// UTF-8 text detector package
// Byte classes, sequence length limits and the classifier result type.
// ----------------------------------------------------------------------------
package utd_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned PendW = 3;

  // Longest run of continuation bytes a lead byte may open
  localparam logic [PendW-1:0] MaxPend = 3'd5;

  // Top two bits of continuation and lead bytes
  localparam logic [1:0] ContTag = 2'b10;
  localparam logic [1:0] LeadTag = 2'b11;

  // Printable range, the allowed control bytes and the terminator
  localparam logic [ByteW-1:0] PrintLo = 8'h20;
  localparam logic [ByteW-1:0] PrintHi = 8'h7E;
  localparam logic [ByteW-1:0] BelChr  = 8'h07;
  localparam logic [ByteW-1:0] LfChr   = 8'h0A;
  localparam logic [ByteW-1:0] FfChr   = 8'h0C;
  localparam logic [ByteW-1:0] CrChr   = 8'h0D;
  localparam logic [ByteW-1:0] EscChr  = 8'h1B;
  localparam logic [ByteW-1:0] NulChr  = 8'h00;

  typedef enum logic [2:0] {
    CLS_TERM,
    CLS_TEXT,
    CLS_CTRL,
    CLS_CONT,
    CLS_LEAD,
    CLS_BADLEAD
  } byte_cls_e;

  typedef struct packed {
    byte_cls_e        cls;
    logic [PendW-1:0] lead_len;
  } byte_info_t;

endpackage

// ----- rtl/core/utd_classify.sv -----
// ----------------------------------------------------------------------------
// UTF-8 text detector byte classifier
// Sorts one byte into terminator, text, bad control, continuation, lead or bad lead.
// ----------------------------------------------------------------------------
module utd_classify (
  input  logic [utd_pkg::ByteW-1:0] byte_i,
  output utd_pkg::byte_info_t       info_o
);

  logic is_text;

  // Match the allowed seven-bit characters
  always_comb begin
    is_text = ((byte_i >= utd_pkg::PrintLo) && (byte_i <= utd_pkg::PrintHi)) ||
              ((byte_i >= utd_pkg::BelChr) && (byte_i <= utd_pkg::LfChr)) ||
              (byte_i == utd_pkg::FfChr) || (byte_i == utd_pkg::CrChr) ||
              (byte_i == utd_pkg::EscChr);
  end

  // Decode class and sequence length from the leading ones
  always_comb begin
    info_o.lead_len = '0;
    if (byte_i == utd_pkg::NulChr) begin
      info_o.cls = utd_pkg::CLS_TERM;
    end else if (!byte_i[7]) begin
      info_o.cls = is_text ? utd_pkg::CLS_TEXT : utd_pkg::CLS_CTRL;
    end else if (byte_i[7:6] == utd_pkg::ContTag) begin
      info_o.cls = utd_pkg::CLS_CONT;
    end else begin
      info_o.cls = utd_pkg::CLS_LEAD;
      if (!byte_i[5]) begin
        info_o.lead_len = 3'd1;
      end else if (!byte_i[4]) begin
        info_o.lead_len = 3'd2;
      end else if (!byte_i[3]) begin
        info_o.lead_len = 3'd3;
      end else if (!byte_i[2]) begin
        info_o.lead_len = 3'd4;
      end else if (!byte_i[1]) begin
        info_o.lead_len = utd_pkg::MaxPend;
      end else begin
        info_o.cls = utd_pkg::CLS_BADLEAD;
      end
    end
  end

endmodule

// ----- rtl/core/utd_track.sv -----
// ----------------------------------------------------------------------------
// UTF-8 text detector string tracker
// Holds per-string state and forms the verdict when the terminator arrives.
// ----------------------------------------------------------------------------
`include "utf8_text_detector_core_macros.svh"

module utd_track (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  utd_pkg::byte_info_t info_i,
  output logic                verdict_o
);

  logic [utd_pkg::PendW-1:0] pend_q, pend_d;
  logic                      seen_q, seen_d;
  logic                      rej_q, rej_d;

  assign verdict_o = !rej_q && seen_q;

  // Advance the string state by one byte
  always_comb begin
    pend_d = pend_q;
    seen_d = seen_q;
    rej_d  = rej_q;
    if (step_i) begin
      if (info_i.cls == utd_pkg::CLS_TERM) begin
        pend_d = '0;
        seen_d = 1'b0;
        rej_d  = 1'b0;
      end else if (rej_q) begin
        // drop bytes until the terminator
      end else if (pend_q != '0) begin
        if (info_i.cls != utd_pkg::CLS_CONT) begin
          rej_d = 1'b1;
        end else begin
          pend_d = pend_q - 3'd1;
          if (pend_q == 3'd1) begin
            seen_d = 1'b1;
          end
        end
      end else begin
        unique case (info_i.cls)
          utd_pkg::CLS_TEXT: ;
          utd_pkg::CLS_LEAD: pend_d = info_i.lead_len;
          default:           rej_d = 1'b1;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
      seen_q <= 1'b0;
      rej_q  <= 1'b0;
    end else begin
      pend_q <= pend_d;
      seen_q <= seen_d;
      rej_q  <= rej_d;
    end
  end

  `UTD_ASSERT_IMPL(a_pend_range, 1'b1, pend_q <= utd_pkg::MaxPend)
  `UTD_ASSERT_NEXT(a_term_clears, step_i && info_i.cls == utd_pkg::CLS_TERM,
                   pend_q == '0 && !seen_q && !rej_q)
  `UTD_ASSERT_NEXT(a_reject_sticks, step_i && rej_q && info_i.cls != utd_pkg::CLS_TERM,
                   rej_q)

endmodule

// ----- rtl/core/utf8_text_detector_core.sv -----
// ----------------------------------------------------------------------------
// UTF-8 text detector core
// Checks NUL-terminated strings, one byte per word, for multibyte UTF-8 text.
// ----------------------------------------------------------------------------
// Input channel: in_valid_i / in_stall_o carry text_byte_i, one string byte
// per word; a zero byte ends the string. Output channel: out_valid_o /
// out_stall_i carry looks_utf8_o, one word per terminator and none for
// other bytes. looks_utf8_o is 1 when the string held only allowed text
// characters and unbroken sequences and at least one complete multibyte
// sequence; a sequence cut short by the terminator is not rejected.
// A terminator moves from the input register into the result register,
// where its verdict shows on the output. Throughput: one byte per cycle
// while no terminator is held, set by the single register-to-register
// pass through the classifier and the state update. The input register
// takes a new byte while a verdict waits in the output register; only a
// terminator stalls while the output register is full and held, and the
// input side stalls back with it. Reset clears both valid flags and the
// string state; the first byte after reset starts a new string.
// ----------------------------------------------------------------------------
module utf8_text_detector_core (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [utd_pkg::ByteW-1:0] text_byte_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic                      looks_utf8_o
);

  logic                      in_valid_q, in_valid_d;
  logic [utd_pkg::ByteW-1:0] byte_q;
  logic                      out_valid_q, out_valid_d;
  logic                      looks_q;
  logic                      out_free;
  logic                      is_term;
  logic                      step;
  logic                      accept;
  logic                      verdict;
  utd_pkg::byte_info_t       info;

  utd_classify u_classify (
    .byte_i (byte_q),
    .info_o (info)
  );

  utd_track u_track (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (step),
    .info_i    (info),
    .verdict_o (verdict)
  );

  // Process a held byte unless it is a terminator facing a full, held output
  assign out_free   = !out_valid_q || !out_stall_i;
  assign is_term    = (info.cls == utd_pkg::CLS_TERM);
  assign step       = in_valid_q && (!is_term || out_free);
  assign in_stall_o = in_valid_q && !step;
  assign accept     = in_valid_i && !in_stall_o;

  // Input register
  always_comb begin
    in_valid_d = in_valid_q;
    if (accept) begin
      in_valid_d = 1'b1;
    end else if (step) begin
      in_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      byte_q <= text_byte_i;
    end
  end

  // Result register: load a verdict, drop it once taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (step && is_term) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && is_term) begin
      looks_q <= verdict;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign looks_utf8_o = looks_q;

endmodule
